@@ design/hpe_pkg.sv @@
// Shared types and constants for the Horner polynomial evaluator.
package hpe_pkg;

    localparam int ACC_W    = 64;
    localparam int X_W      = 32;
    localparam int COEF_W   = 16;
    localparam int IDX_IN_W = 4;
    localparam int FRAC_W   = 16;
    localparam int S_DATA_W = 56;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LO   = 5'b00010,
        ST_HI   = 5'b00100,
        ST_SUM  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic start;
        logic mul_lo;
        logic mul_hi;
        logic accum;
    } dp_ctrl_t;

endpackage

@@ design/hpe_datapath.sv @@
// Shared multiplier and saturating accumulator for one Horner step.
module hpe_datapath (
    input  logic                              aclk,
    input  hpe_pkg::dp_ctrl_t                 ctrl,
    input  logic signed [hpe_pkg::X_W-1:0]    x_in,
    input  logic signed [hpe_pkg::COEF_W-1:0] coef,
    output logic [hpe_pkg::ACC_W-1:0]         acc,
    output logic                              ovf
);

    localparam int HALF   = hpe_pkg::ACC_W / 2;
    localparam int OP_W   = HALF + 1;
    localparam int PROD_W = OP_W + hpe_pkg::X_W;
    localparam int TOT_W  = PROD_W + HALF + 1;
    localparam int SH_W   = TOT_W - hpe_pkg::FRAC_W;
    localparam int UP_W   = SH_W - hpe_pkg::ACC_W + 1;

    logic signed [hpe_pkg::X_W-1:0] x_reg;
    logic [hpe_pkg::ACC_W-1:0]      acc_reg;
    logic                           ovf_reg;
    logic signed [PROD_W-1:0]       pl_reg;
    logic signed [PROD_W-1:0]       ph_reg;

    logic signed [OP_W-1:0]    op_a;
    logic signed [PROD_W-1:0]  prod;
    logic [TOT_W-1:0]          total;
    logic [SH_W-1:0]           shifted;
    logic [UP_W-1:0]           upper;
    logic                      fits;
    logic [hpe_pkg::ACC_W-1:0] acc_next;

    always_comb begin
        if (ctrl.mul_hi) begin
            op_a = $signed({acc_reg[hpe_pkg::ACC_W-1], acc_reg[hpe_pkg::ACC_W-1:HALF]});
        end else begin
            op_a = $signed({1'b0, acc_reg[HALF-1:0]});
        end
        prod    = op_a * x_reg;
        total   = {ph_reg[PROD_W-1], ph_reg, {HALF{1'b0}}}
                + {{(TOT_W-PROD_W){pl_reg[PROD_W-1]}}, pl_reg};
        shifted = total[TOT_W-1:hpe_pkg::FRAC_W];
        upper   = shifted[SH_W-1:hpe_pkg::ACC_W-1];
        fits    = (&upper) | ~(|upper);
        if (fits) begin
            acc_next = shifted[hpe_pkg::ACC_W-1:0];
        end else if (shifted[SH_W-1]) begin
            acc_next = {1'b1, {(hpe_pkg::ACC_W-1){1'b0}}};
        end else begin
            acc_next = {1'b0, {(hpe_pkg::ACC_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            x_reg   <= x_in;
            acc_reg <= '0;
            ovf_reg <= 1'b0;
        end
        if (ctrl.mul_lo) begin
            pl_reg <= prod;
        end
        if (ctrl.mul_hi) begin
            ph_reg <= prod + PROD_W'(coef);
        end
        if (ctrl.accum) begin
            acc_reg <= acc_next;
            ovf_reg <= ovf_reg | ~fits;
        end
    end

    assign acc = acc_reg;
    assign ovf = ovf_reg;

endmodule

@@ design/horner_polynomial_evaluator.sv @@
// Top level of the Horner polynomial evaluator: coefficient store, sequencer and stream ports.
//
// A load request writes one 16-bit signed coefficient. An evaluate request computes p(x) for
// Q16.16 x from the configured degree d down to power 0 in a saturating Q47.16 accumulator
// and returns one result; it keeps the input side busy until that result is stored. Each
// coefficient passes through ST_LO, ST_HI and ST_SUM because a single 33x32 signed
// multiplier forms the low and high partial products of acc*x one after the other, and
// ST_SUM does the 98-bit sum, shift and clamp. The result register frees the unit as soon
// as a result is stored, and the next request is taken while it waits; a later result
// waits only if the earlier one is still pending.
module horner_polynomial_evaluator #(
    parameter int MAX_TERMS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [3:0]                      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // coef_index [3:0], coef_value [19:4], x_value [51:20], zero fill above.
    input  logic [hpe_pkg::S_DATA_W-1:0]    s_tdata,
    // req_type.
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // poly_value [63:0].
    output logic [hpe_pkg::ACC_W-1:0]       m_tdata,
    // overflowed.
    output logic                            m_tuser
);

    localparam int DEPTH = (MAX_TERMS < 16) ? MAX_TERMS : 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [hpe_pkg::IDX_IN_W:0] DEPTH_CMP = (hpe_pkg::IDX_IN_W + 1)'(DEPTH);

    hpe_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [3:0]       degree_reg;
    logic signed [hpe_pkg::COEF_W-1:0] coef_reg [DEPTH];

    logic                      m_tvalid_reg;
    logic [hpe_pkg::ACC_W-1:0] m_tdata_reg;
    logic                      m_tuser_reg;

    logic [hpe_pkg::IDX_IN_W-1:0]      in_idx;
    logic signed [hpe_pkg::COEF_W-1:0] in_coef;
    logic signed [hpe_pkg::X_W-1:0]    in_x;
    logic                              in_acc;
    logic [IDX_W-1:0]                  d_eff;
    logic [IDX_W-1:0]                  rd_idx;
    logic                              out_load;
    hpe_pkg::dp_ctrl_t                 ctrl;
    logic [hpe_pkg::ACC_W-1:0]         acc;
    logic                              ovf;

    assign in_idx  = s_tdata[3:0];
    assign in_coef = $signed(s_tdata[19:4]);
    assign in_x    = $signed(s_tdata[51:20]);
    assign s_tready = (state_reg == hpe_pkg::ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign d_eff    = ({1'b0, degree_reg} >= DEPTH_CMP) ? IDX_W'(DEPTH - 1)
                                                        : degree_reg[IDX_W-1:0];
    assign rd_idx   = IDX_W'(cnt_reg - CNT_W'(1));
    assign out_load = (state_reg == hpe_pkg::ST_OUT) & (~m_tvalid_reg | m_tready);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        unique case (state_reg)
            hpe_pkg::ST_IDLE: begin
                if (in_acc && s_tuser == hpe_pkg::REQ_EVAL) begin
                    ctrl.start = 1'b1;
                    cnt_next   = CNT_W'(d_eff) + CNT_W'(1);
                    state_next = hpe_pkg::ST_LO;
                end
            end
            hpe_pkg::ST_LO: begin
                ctrl.mul_lo = 1'b1;
                state_next  = hpe_pkg::ST_HI;
            end
            hpe_pkg::ST_HI: begin
                ctrl.mul_hi = 1'b1;
                state_next  = hpe_pkg::ST_SUM;
            end
            hpe_pkg::ST_SUM: begin
                ctrl.accum = 1'b1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = hpe_pkg::ST_OUT;
                end else begin
                    state_next = hpe_pkg::ST_LO;
                end
            end
            hpe_pkg::ST_OUT: begin
                if (out_load) begin
                    state_next = hpe_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = hpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hpe_pkg::ST_IDLE;
            cnt_reg      <= '0;
            degree_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                coef_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we) begin
                degree_reg <= cfg_wdata;
            end
            if (in_acc && s_tuser == hpe_pkg::REQ_LOAD && {1'b0, in_idx} < DEPTH_CMP) begin
                coef_reg[in_idx[IDX_W-1:0]] <= in_coef;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= acc;
            m_tuser_reg <= ovf;
        end
    end

    hpe_datapath u_datapath (
        .aclk (aclk),
        .ctrl (ctrl),
        .x_in (in_x),
        .coef (coef_reg[rd_idx]),
        .acc  (acc),
        .ovf  (ovf)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_out_after_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hpe_pkg::ST_OUT) |->
            ($past(state_reg) == hpe_pkg::ST_SUM || $past(state_reg) == hpe_pkg::ST_OUT))
        else $error("Result stage entered without a final accumulate.");

    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == hpe_pkg::ST_LO || state_reg == hpe_pkg::ST_HI ||
         state_reg == hpe_pkg::ST_SUM) |-> (cnt_reg != '0))
        else $error("Term counter is zero while a step is in progress.");

    a_eval_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == hpe_pkg::REQ_EVAL) |=>
            (state_reg == hpe_pkg::ST_LO))
        else $error("Evaluate request did not start the step sequence.");

endmodule

@@ tb/testbench.sv @@
// Self-checking stream testbench for the Horner polynomial evaluator.
`timescale 1ns / 1ps

module testbench;

    localparam int TERMS = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 60;
    localparam logic signed [127:0] ACC_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] ACC_MIN = -ACC_MAX - 128'sd1;

    typedef struct {
        logic               req;
        logic [3:0]         idx;
        logic signed [15:0] coef;
        logic signed [31:0] x;
    } poly_req_t;

    typedef struct {
        logic [63:0] value;
        logic        sat;
    } poly_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [3:0]                    cfg_wdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [hpe_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic                          s_tuser = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [hpe_pkg::ACC_W-1:0]     m_tdata;
    logic                          m_tuser;

    poly_req_t             requests_to_send[$];
    poly_result_t          poly_results_due[$];
    poly_req_t             req_on_bus;
    logic signed [15:0]    coef_bank [TERMS];
    logic [3:0]            poly_degree = '0;
    bit                    idle_on = 1'b0;
    int                    mismatches = 0;
    int                    results_checked = 0;
    int                    send_gap = 0;
    int                    recv_gap = 0;
    int                    hold_left = 0;
    bit                    hold_done = 1'b0;
    int                    quiet_cycles = 0;

    horner_polynomial_evaluator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic poly_result_t horner_eval(input logic signed [31:0] x);
        poly_result_t       res;
        logic signed [63:0] acc;
        logic signed [127:0] wide;
        logic signed [127:0] term;
        int                 p;
        res.sat = 1'b0;
        acc = 64'(coef_bank[poly_degree]);
        acc = acc <<< 16;
        for (p = int'(poly_degree); p > 0; p--) begin
            wide = 128'(acc) * 128'(x);
            term = 128'(coef_bank[p - 1]);
            wide = (wide >>> 16) + (term <<< 16);
            if (wide > ACC_MAX) begin
                acc = ACC_MAX[63:0];
                res.sat = 1'b1;
            end else if (wide < ACC_MIN) begin
                acc = ACC_MIN[63:0];
                res.sat = 1'b1;
            end else begin
                acc = wide[63:0];
            end
        end
        res.value = acc;
        return res;
    endfunction

    task automatic queue_load(input logic [3:0] idx, input logic signed [15:0] coef);
        poly_req_t r;
        r.req = hpe_pkg::REQ_LOAD;
        r.idx = idx;
        r.coef = coef;
        r.x = $urandom();
        requests_to_send.push_back(r);
    endtask

    task automatic queue_eval(input logic signed [31:0] x);
        poly_req_t r;
        r.req = hpe_pkg::REQ_EVAL;
        r.idx = 4'($urandom_range(0, 15));
        r.coef = 16'($urandom());
        r.x = x;
        requests_to_send.push_back(r);
    endtask

    task automatic write_degree(input logic [3:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= d;
        @(posedge aclk);
        cfg_we <= 1'b0;
        poly_degree = d;
    endtask

    task automatic drain;
        while (requests_to_send.size() != 0 || s_tvalid || poly_results_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (req_on_bus.req == hpe_pkg::REQ_LOAD)
                    coef_bank[req_on_bus.idx] = req_on_bus.coef;
                else
                    poly_results_due.push_back(horner_eval(req_on_bus.x));
            end
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (idle_on && requests_to_send.size() != 0 && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 8);
                s_tvalid <= 1'b0;
            end else if (requests_to_send.size() != 0) begin
                req_on_bus = requests_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{(hpe_pkg::S_DATA_W - 52){1'b0}}, req_on_bus.x, req_on_bus.coef,
                            req_on_bus.idx};
                s_tuser <= req_on_bus.req;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        poly_result_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (poly_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual value %h overflow %b",
                             $time, m_tdata, m_tuser);
                end else begin
                    due = poly_results_due.pop_front();
                    if (m_tdata !== due.value) begin
                        mismatches++;
                        $display("%0t: poly_value mismatch, expected %h, actual %h",
                                 $time, due.value, m_tdata);
                    end
                    if (m_tuser !== due.sat) begin
                        mismatches++;
                        $display("%0t: overflowed mismatch, expected %b, actual %b",
                                 $time, due.sat, m_tuser);
                    end
                    results_checked++;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_checked >= 150) begin
                hold_done = 1'b1;
                hold_left = 399;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 8);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int                 ph;
        int                 n;
        int                 k;
        logic [3:0]         deg;
        logic signed [15:0] c;
        logic signed [31:0] x;
        for (k = 0; k < TERMS; k++)
            coef_bank[k] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // The store must read as zero right after reset; degree is still at its reset value.
        queue_eval(32'sd0);
        queue_load(4'd0, -16'sd32768);
        queue_eval(32'sh7FFF_FFFF);
        queue_load(4'd0, 16'sd32767);
        queue_eval(32'sh8000_0000);
        drain();

        write_degree(4'd15);
        for (k = 15; k >= 0; k--)
            queue_load(k[3:0], 16'sd32767);
        queue_eval(32'sh7FFF_FFFF);
        queue_eval(32'sh8000_0000);
        queue_eval(32'sd65536);
        queue_eval(-32'sd65536);
        drain();

        for (ph = 0; ph < 10; ph++) begin
            deg = (ph == 0) ? 4'd0 : (ph == 1) ? 4'd15 : 4'($urandom_range(0, 15));
            idle_on = (ph != 9) && (ph % 3 != 2);
            write_degree(deg);
            for (n = 0; n < 100; n++) begin
                case ($urandom_range(0, 7))
                    0: c = 16'sh8000;
                    1: c = 16'sh7FFF;
                    2, 3: c = 16'(int'($urandom_range(0, 16)) - 8);
                    default: c = 16'($urandom());
                endcase
                case ($urandom_range(0, 7))
                    0: begin
                        case ($urandom_range(0, 4))
                            0: x = 32'sh8000_0000;
                            1: x = 32'sh7FFF_FFFF;
                            2: x = 32'sd0;
                            3: x = 32'sd65536;
                            default: x = -32'sd65536;
                        endcase
                    end
                    1, 2, 3: x = int'($urandom_range(0, 262144)) - 131072;
                    default: x = $urandom();
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 4) == 0)
                        queue_load(4'($urandom_range(0, 15)), c);
                    else
                        queue_load(4'($urandom_range(0, int'(deg))), c);
                end else begin
                    queue_eval(x);
                end
            end
            drain();
        end

        if (mismatches == 0 && poly_results_due.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
design/hpe_pkg.sv
design/hpe_datapath.sv
design/horner_polynomial_evaluator.sv
tb/testbench.sv
